>>> sv/lms_pkg.sv
// lamp matrix scanner package: request codes, field widths and the
// controller/datapath command and status types; no dependencies
`default_nettype none

package lms_pkg;

	localparam int unsigned ROWS      = 8;
	localparam int unsigned ROW_W     = 3;
	localparam int unsigned COL_W     = 8;
	localparam int unsigned LAMP_W    = 6;
	localparam int unsigned REQ_W     = 3;
	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 24;

	typedef enum logic [REQ_W-1:0] {
		REQ_LAMP_ON  = 3'd0,
		REQ_LAMP_OFF = 3'd1,
		REQ_TOGGLE   = 3'd2,
		REQ_LAMP_SET = 3'd3,
		REQ_ROW_WR   = 3'd4,
		REQ_ALL_OFF  = 3'd5,
		REQ_ALL_ON   = 3'd6,
		REQ_TICK     = 3'd7
	} req_t;

	typedef struct packed {
		logic apply;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
	} status_t;

endpackage

`default_nettype wire

>>> sv/lamp_matrix_scanner.sv
// Lamp matrix scanner: holds an 8x8 lamp bitmap (all off after reset) that
// commands on the input stream edit, and emits one row drive per scan tick.
// The block accepts one transaction per cycle as long as the output register
// is empty or being read in the same cycle. A scan tick result is registered
// and appears in the cycle after its transaction. Commands give no
// output. tuser carries the request type; tick results carry one-hot row
// select, active-low column byte and the row index.
`default_nettype none

module lamp_matrix_scanner (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// lamp_number[5:0], lamp_value[6], row_index[9:7], row_data[17:10]
	input  wire logic [lms_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// req_type[2:0]
	input  wire logic [lms_pkg::REQ_W-1:0]         s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// row_select[7:0], column_drive[15:8], scanned_row[18:16]
	output logic      [lms_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	lms_pkg::cmd_t             cmd;
	lms_pkg::status_t          status;
	logic [lms_pkg::ROWS-1:0]  row_select;
	logic [lms_pkg::COL_W-1:0] column_drive;
	logic [lms_pkg::ROW_W-1:0] scanned_row;

	lms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	lms_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.req_type     (s_axis_tuser),
		.lamp_number  (s_axis_tdata[5:0]),
		.lamp_value   (s_axis_tdata[6]),
		.row_index    (s_axis_tdata[9:7]),
		.row_data     (s_axis_tdata[17:10]),
		.row_select   (row_select),
		.column_drive (column_drive),
		.scanned_row  (scanned_row)
	);

	assign m_axis_tdata = {5'd0, scanned_row, column_drive, row_select};

	a_tick_gives_output: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == lms_pkg::REQ_TICK)
		|=> m_axis_tvalid)
		else $error("tick transaction produced no output");

	a_cmd_gives_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser != lms_pkg::REQ_TICK
		 && !m_axis_tvalid) |=> !m_axis_tvalid)
		else $error("command transaction produced output");

	a_row_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot(m_axis_tdata[7:0]))
		else $error("row select not one-hot");

	a_row_matches_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:0] == (8'd1 << m_axis_tdata[18:16])))
		else $error("row select disagrees with scanned row");

endmodule

`default_nettype wire

>>> sv/lms_ctrl.sv
// lamp matrix scanner controller: handshake and output slot state machine
// depends on lms_pkg
`default_nettype none

module lms_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire lms_pkg::status_t status,
	output lms_pkg::cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_EMPTY = 2'b01,
		ST_FULL  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign out_valid = (state_q == ST_FULL);
	assign in_ready  = (state_q == ST_EMPTY) || out_ready;
	assign accept    = in_valid && in_ready;

	always_comb begin
		cmd.apply    = accept;
		cmd.load_out = accept && status.is_tick;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_EMPTY: begin
				if (accept && status.is_tick) state_nxt = ST_FULL;
			end
			ST_FULL: begin
				if (accept && status.is_tick) state_nxt = ST_FULL;
				else if (out_ready)           state_nxt = ST_EMPTY;
			end
			default: state_nxt = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_EMPTY;
		else         state_q <= state_nxt;
	end

endmodule

`default_nettype wire

>>> sv/lms_dp.sv
// lamp matrix scanner datapath: per-row lamp registers, scan counter and
// output register; depends on lms_pkg
`default_nettype none

module lms_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire lms_pkg::cmd_t                    cmd,
	output lms_pkg::status_t                      status,
	input  wire logic [lms_pkg::REQ_W-1:0]        req_type,
	input  wire logic [lms_pkg::LAMP_W-1:0]       lamp_number,
	input  wire logic                             lamp_value,
	input  wire logic [lms_pkg::ROW_W-1:0]        row_index,
	input  wire logic [lms_pkg::COL_W-1:0]        row_data,
	output logic      [lms_pkg::ROWS-1:0]         row_select,
	output logic      [lms_pkg::COL_W-1:0]        column_drive,
	output logic      [lms_pkg::ROW_W-1:0]        scanned_row
);

	logic [lms_pkg::COL_W-1:0] lamp_q   [lms_pkg::ROWS];
	logic [lms_pkg::COL_W-1:0] lamp_nxt [lms_pkg::ROWS];
	logic [lms_pkg::ROW_W-1:0] scan_q;
	logic [lms_pkg::ROW_W-1:0] lamp_row;
	logic [lms_pkg::COL_W-1:0] lamp_bit;
	lms_pkg::req_t             req;

	logic [lms_pkg::ROWS-1:0]  row_select_q;
	logic [lms_pkg::COL_W-1:0] column_drive_q;
	logic [lms_pkg::ROW_W-1:0] scanned_row_q;

	assign req            = lms_pkg::req_t'(req_type);
	assign status.is_tick = (req == lms_pkg::REQ_TICK);
	assign lamp_row       = lamp_number[lms_pkg::LAMP_W-1:lms_pkg::ROW_W];
	assign lamp_bit       = lms_pkg::COL_W'(1) << lamp_number[lms_pkg::ROW_W-1:0];

	// each row computes its own next value
	always_comb begin
		for (int r = 0; r < lms_pkg::ROWS; r++) begin
			lamp_nxt[r] = lamp_q[r];
			case (req)
				lms_pkg::REQ_LAMP_ON: begin
					if (lamp_row == r[lms_pkg::ROW_W-1:0]) lamp_nxt[r] = lamp_q[r] | lamp_bit;
				end
				lms_pkg::REQ_LAMP_OFF: begin
					if (lamp_row == r[lms_pkg::ROW_W-1:0]) lamp_nxt[r] = lamp_q[r] & ~lamp_bit;
				end
				lms_pkg::REQ_TOGGLE: begin
					if (lamp_row == r[lms_pkg::ROW_W-1:0]) lamp_nxt[r] = lamp_q[r] ^ lamp_bit;
				end
				lms_pkg::REQ_LAMP_SET: begin
					if (lamp_row == r[lms_pkg::ROW_W-1:0]) begin
						lamp_nxt[r] = lamp_value ? (lamp_q[r] | lamp_bit)
						                         : (lamp_q[r] & ~lamp_bit);
					end
				end
				lms_pkg::REQ_ROW_WR: begin
					if (row_index == r[lms_pkg::ROW_W-1:0]) lamp_nxt[r] = row_data;
				end
				lms_pkg::REQ_ALL_OFF: lamp_nxt[r] = '0;
				lms_pkg::REQ_ALL_ON:  lamp_nxt[r] = '1;
				default:              lamp_nxt[r] = lamp_q[r];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < lms_pkg::ROWS; r++) lamp_q[r] <= '0;
			scan_q <= '0;
		end else if (cmd.apply) begin
			for (int r = 0; r < lms_pkg::ROWS; r++) lamp_q[r] <= lamp_nxt[r];
			if (cmd.load_out) scan_q <= scan_q + lms_pkg::ROW_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			row_select_q   <= lms_pkg::ROWS'(1) << scan_q;
			column_drive_q <= ~lamp_q[scan_q];
			scanned_row_q  <= scan_q;
		end
	end

	assign row_select   = row_select_q;
	assign column_drive = column_drive_q;
	assign scanned_row  = scanned_row_q;

endmodule

`default_nettype wire

>>> test/tb_lamp_matrix_scanner.sv
// testbench for lamp_matrix_scanner: directed table then random commands and scan ticks,
// every row drive checked against the table's expectation or an in-bench bitmap predictor
// depends on lms_pkg and lamp_matrix_scanner
`default_nettype none

module tb_lamp_matrix_scanner;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_HOLD  = 60;
	localparam int BURST_LEN  = 30;
	localparam int CHUNKS     = 8;
	localparam int CHUNK_LEN  = 45;
	localparam int PLAN_LEN   = 27;

	typedef struct packed {
		logic [7:0] sel;
		logic [7:0] col;
		logic [2:0] row;
	} row_drive_t;

	typedef struct packed {
		lms_pkg::req_t kind;
		logic [5:0]    num;
		logic          val;
		logic [2:0]    ridx;
		logic [7:0]    data;
		logic          known;
		row_drive_t    want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [lms_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [lms_pkg::REQ_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [lms_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	logic [7:0] lamp_bitmap [0:lms_pkg::ROWS-1];
	logic [2:0] next_scan_row;
	row_drive_t pending_drives [$];

	int mismatches = 0;
	int requests_sent = 0;
	int ticks_sent = 0;
	int drives_checked = 0;
	bit tx_jitter = 1'b1;
	bit rx_jitter = 1'b1;
	bit hold_output = 1'b0;
	int stall_left = 0;

	step_t plan [0:PLAN_LEN-1] = '{
		'{lms_pkg::REQ_TICK,     6'd63, 1'b1, 3'd7, 8'hff, 1'b1, '{8'h01, 8'hff, 3'd0}},
		'{lms_pkg::REQ_LAMP_ON,  6'd63, 1'b0, 3'd0, 8'h00, 1'b0, '0},
		'{lms_pkg::REQ_LAMP_ON,  6'd0,  1'b1, 3'd7, 8'hff, 1'b0, '0},
		'{lms_pkg::REQ_TICK,     6'd0,  1'b0, 3'd0, 8'h00, 1'b0, '0},
		'{lms_pkg::REQ_ALL_ON,   6'd21, 1'b0, 3'd5, 8'h5a, 1'b0, '0},
		'{lms_pkg::REQ_TICK,     6'd0,  1'b0, 3'd0, 8'h00, 1'b1, '{8'h04, 8'h00, 3'd2}},
		'{lms_pkg::REQ_TICK,     6'd0,  1'b0, 3'd0, 8'h00, 1'b1, '{8'h08, 8'h00, 3'd3}},
		'{lms_pkg::REQ_TICK,     6'd0,  1'b0, 3'd0, 8'h00, 1'b1, '{8'h10, 8'h00, 3'd4}},
		'{lms_pkg::REQ_TICK,     6'd0,  1'b0, 3'd0, 8'h00, 1'b1, '{8'h20, 8'h00, 3'd5}},
		'{lms_pkg::REQ_TICK,     6'd0,  1'b0, 3'd0, 8'h00, 1'b1, '{8'h40, 8'h00, 3'd6}},
		'{lms_pkg::REQ_TICK,     6'd0,  1'b0, 3'd0, 8'h00, 1'b1, '{8'h80, 8'h00, 3'd7}},
		'{lms_pkg::REQ_TICK,     6'd0,  1'b0, 3'd0, 8'h00, 1'b1, '{8'h01, 8'h00, 3'd0}},
		'{lms_pkg::REQ_ALL_OFF,  6'd63, 1'b1, 3'd7, 8'hff, 1'b0, '0},
		'{lms_pkg::REQ_TICK,     6'd63, 1'b1, 3'd7, 8'hff, 1'b1, '{8'h02, 8'hff, 3'd1}},
		'{lms_pkg::REQ_ROW_WR,   6'd0,  1'b0, 3'd2, 8'ha5, 1'b0, '0},
		'{lms_pkg::REQ_TICK,     6'd0,  1'b0, 3'd0, 8'h00, 1'b0, '0},
		'{lms_pkg::REQ_TOGGLE,   6'd27, 1'b0, 3'd0, 8'h00, 1'b0, '0},
		'{lms_pkg::REQ_TOGGLE,   6'd24, 1'b1, 3'd3, 8'hff, 1'b0, '0},
		'{lms_pkg::REQ_TICK,     6'd0,  1'b0, 3'd0, 8'h00, 1'b0, '0},
		'{lms_pkg::REQ_LAMP_SET, 6'd36, 1'b1, 3'd0, 8'h00, 1'b0, '0},
		'{lms_pkg::REQ_LAMP_SET, 6'd37, 1'b0, 3'd4, 8'hff, 1'b0, '0},
		'{lms_pkg::REQ_LAMP_SET, 6'd39, 1'b1, 3'd0, 8'h00, 1'b0, '0},
		'{lms_pkg::REQ_TICK,     6'd0,  1'b0, 3'd0, 8'h00, 1'b0, '0},
		'{lms_pkg::REQ_LAMP_OFF, 6'd39, 1'b1, 3'd7, 8'hff, 1'b0, '0},
		'{lms_pkg::REQ_ROW_WR,   6'd63, 1'b1, 3'd7, 8'hff, 1'b0, '0},
		'{lms_pkg::REQ_ROW_WR,   6'd0,  1'b0, 3'd0, 8'h00, 1'b0, '0},
		'{lms_pkg::REQ_TICK,     6'd0,  1'b0, 3'd0, 8'h00, 1'b0, '0}
	};

	lamp_matrix_scanner uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic apply_request(input lms_pkg::req_t kind, input logic [5:0] num,
			input logic val, input logic [2:0] ridx, input logic [7:0] data,
			output logic gives, output row_drive_t drv);
		logic [2:0] r;
		logic [7:0] b;
		r = num[5:3];
		b = 8'h01 << num[2:0];
		gives = 1'b0;
		drv = '0;
		case (kind)
			lms_pkg::REQ_LAMP_ON:  lamp_bitmap[r] = lamp_bitmap[r] | b;
			lms_pkg::REQ_LAMP_OFF: lamp_bitmap[r] = lamp_bitmap[r] & ~b;
			lms_pkg::REQ_TOGGLE:   lamp_bitmap[r] = lamp_bitmap[r] ^ b;
			lms_pkg::REQ_LAMP_SET:
				lamp_bitmap[r] = val ? (lamp_bitmap[r] | b) : (lamp_bitmap[r] & ~b);
			lms_pkg::REQ_ROW_WR:   lamp_bitmap[ridx] = data;
			lms_pkg::REQ_ALL_OFF:  foreach (lamp_bitmap[i]) lamp_bitmap[i] = 8'h00;
			lms_pkg::REQ_ALL_ON:   foreach (lamp_bitmap[i]) lamp_bitmap[i] = 8'hff;
			default: begin
				gives = 1'b1;
				drv.sel = 8'h01 << next_scan_row;
				drv.col = ~lamp_bitmap[next_scan_row];
				drv.row = next_scan_row;
				next_scan_row = next_scan_row + 3'd1;
			end
		endcase
	endtask

	task automatic offer(input lms_pkg::req_t kind, input logic [5:0] num, input logic val,
			input logic [2:0] ridx, input logic [7:0] data,
			input logic known, input row_drive_t typed);
		int gap;
		logic gives;
		row_drive_t drv;
		gap = tx_jitter ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {6'b0, data, ridx, val, num};
		s_axis_tuser = kind;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		apply_request(kind, num, val, ridx, data, gives, drv);
		if (gives) begin
			pending_drives.push_back(known ? typed : drv);
			ticks_sent++;
		end
		requests_sent++;
	endtask

	task automatic offer_random();
		int r;
		lms_pkg::req_t kind;
		r = $urandom_range(0, 99);
		if (r < 35)
			kind = lms_pkg::REQ_TICK;
		else if (r < 37)
			kind = lms_pkg::REQ_ALL_OFF;
		else if (r < 39)
			kind = lms_pkg::REQ_ALL_ON;
		else
			kind = lms_pkg::req_t'($urandom_range(0, 4));
		offer(kind, 6'($urandom), 1'($urandom), 3'($urandom), 8'($urandom), 1'b0, '0);
	endtask

	task automatic idle_sender();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_drives.size() != 0) @(posedge clk);
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready = 1'b0;
			stall_left--;
		end else begin
			m_axis_tready = 1'b1;
			if (hold_output) begin
				stall_left = LONG_HOLD;
				hold_output = 1'b0;
			end else if (rx_jitter) begin
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		row_drive_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_drives.size() == 0) begin
				flag_mismatch("unexpected transaction", int'(m_axis_tdata), 0);
			end else begin
				want = pending_drives.pop_front();
				if (m_axis_tdata[7:0] !== want.sel)
					flag_mismatch("row_select", int'(m_axis_tdata[7:0]), int'(want.sel));
				if (m_axis_tdata[15:8] !== want.col)
					flag_mismatch("column_drive", int'(m_axis_tdata[15:8]), int'(want.col));
				if (m_axis_tdata[18:16] !== want.row)
					flag_mismatch("scanned_row", int'(m_axis_tdata[18:16]), int'(want.row));
				drives_checked++;
			end
		end
	end

	initial begin
		#1000000;
		$display("timeout with %0d row drives outstanding", pending_drives.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		foreach (lamp_bitmap[i]) lamp_bitmap[i] = 8'h00;
		next_scan_row = 3'd0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i])
			offer(plan[i].kind, plan[i].num, plan[i].val, plan[i].ridx, plan[i].data,
				plan[i].known, plan[i].want);
		idle_sender();
		wait_drained();

		for (int c = 0; c < CHUNKS; c++) begin
			tx_jitter = ($urandom_range(0, 3) != 0);
			rx_jitter = ($urandom_range(0, 3) != 0);
			repeat (CHUNK_LEN) offer_random();
			if (c == 2) begin
				tx_jitter = 1'b0;
				hold_output = 1'b1;
				repeat (BURST_LEN) offer(lms_pkg::REQ_TICK, 6'($urandom), 1'($urandom),
					3'($urandom), 8'($urandom), 1'b0, '0);
			end
			if (c == 5) begin
				idle_sender();
				wait_drained();
			end
		end
		idle_sender();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("sent %0d transactions (%0d scan ticks), checked %0d row drives",
			requests_sent, ticks_sent, drives_checked);
		$display("directed corners, long output hold and drain pause included");
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
